### rtl/core/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, codes and character tables for the streaming base64 codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int unsigned LINE_CHARS_DEF = 64;
  localparam int unsigned MAX_RES        = 5;
  localparam int unsigned CNT_W          = 3;   // holds 0..MAX_RES

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_PAD = 8'h3D;

  // character classes from the decode classifier (0..63 are sextets)
  localparam logic [6:0] CODE_PAD  = 7'd64;
  localparam logic [6:0] CODE_SKIP = 7'd65;
  localparam logic [6:0] CODE_BAD  = 7'd66;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // register indexes
  localparam logic REG_MODE = 1'b0;

  typedef struct packed {
    logic [7:0] ob;
    logic       last;
    logic       err;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   n;
  } res_list_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62) c = 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) c = 8'h2B;
    else                 c = 8'h2F;
    return c;
  endfunction

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A)      v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B)               v = 7'd62;
    else if (c == 8'h2F)               v = 7'd63;
    else if (c == CH_PAD)              v = CODE_PAD;
    else if (c == 8'h20 || c == 8'h09 || c == CH_NL) v = CODE_SKIP;
    else                               v = CODE_BAD;
    return v;
  endfunction

endpackage

### rtl/core/b64sc_if.sv
// ----------------------------------------------------------------------------
// b64sc_if
// Valid/ready stream interfaces for the codec input and result channels.
// ----------------------------------------------------------------------------
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       error;

  modport source (output valid, output out_byte, output out_last, output error,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input error,
                  output ready);
endinterface

### rtl/core/b64sc_engine.sv
// ----------------------------------------------------------------------------
// b64sc_engine
// Message state and single-pass encode/decode of one item into its results.
// ----------------------------------------------------------------------------
module b64sc_engine #(
  parameter int unsigned LINE_CHARS = b64sc_pkg::LINE_CHARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mode,
  input  logic                  clr,
  input  logic                  load,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output b64sc_pkg::res_list_t  res
);

  // line length rounded down to whole groups, at least one group
  localparam int unsigned LINE_EFF =
    ((LINE_CHARS / 4) * 4 < 4) ? 4 : (LINE_CHARS / 4) * 4;
  localparam int unsigned LC_W = $clog2(LINE_EFF);
  localparam int unsigned CNT_W = b64sc_pkg::CNT_W;

  logic [1:0]      phase_r, phase_nxt;
  logic [5:0]      carry_r, carry_nxt;
  logic [LC_W-1:0] line_r,  line_nxt;
  logic [1:0]      pad_r,   pad_nxt;
  logic            err_r,   err_nxt;
  logic [7:0]      held_r,  held_nxt;
  logic            held_v_r, held_v_nxt;

  logic [7:0]      ch [4];
  logic [2:0]      nch;
  logic [CNT_W-1:0] k;
  logic [6:0]      v;
  logic            fault;
  logic            emit;
  logic [7:0]      emit_b;

  always_comb begin
    res        = '0;
    phase_nxt  = phase_r;
    carry_nxt  = carry_r;
    line_nxt   = line_r;
    pad_nxt    = pad_r;
    err_nxt    = err_r;
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    for (int i = 0; i < 4; i++) ch[i] = b64sc_pkg::CH_PAD;
    nch    = 3'd0;
    k      = '0;
    v      = b64sc_pkg::classify(in_byte);
    fault  = 1'b0;
    emit   = 1'b0;
    emit_b = 8'h00;

    if (mode == b64sc_pkg::MODE_ENC) begin
      case (phase_r)
        2'd0: begin
          ch[0]     = b64sc_pkg::enc_char(in_byte[7:2]);
          carry_nxt = {in_byte[1:0], 4'b0000};
          phase_nxt = 2'd1;
          nch       = 3'd1;
        end
        2'd1: begin
          ch[0]     = b64sc_pkg::enc_char(carry_r | {2'b00, in_byte[7:4]});
          carry_nxt = {in_byte[3:0], 2'b00};
          phase_nxt = 2'd2;
          nch       = 3'd1;
        end
        default: begin
          ch[0]     = b64sc_pkg::enc_char(carry_r | {4'b0000, in_byte[7:6]});
          ch[1]     = b64sc_pkg::enc_char(in_byte[5:0]);
          carry_nxt = 6'd0;
          phase_nxt = 2'd0;
          nch       = 3'd2;
        end
      endcase
      if (in_last) begin
        if (phase_nxt == 2'd1) begin
          ch[1] = b64sc_pkg::enc_char(carry_nxt);
          nch   = 3'd4;
        end else if (phase_nxt == 2'd2) begin
          ch[1] = b64sc_pkg::enc_char(carry_nxt);
          nch   = 3'd3;
        end
      end
      // characters with a line break after each full line
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < nch) begin
          res.ent[k].ob = ch[i];
          k = k + 1'b1;
          if (line_nxt == LC_W'(LINE_EFF - 1)) begin
            res.ent[k].ob = b64sc_pkg::CH_NL;
            k = k + 1'b1;
            line_nxt = '0;
          end else begin
            line_nxt = line_nxt + 1'b1;
          end
        end
      end
      if (in_last) begin
        if (line_nxt != '0) begin
          res.ent[k].ob = b64sc_pkg::CH_NL;
          k = k + 1'b1;
        end
        res.ent[k - 1'b1].last = 1'b1;
      end
      res.n = k;
    end else begin
      if (!err_r) begin
        if (v == b64sc_pkg::CODE_BAD) begin
          fault = 1'b1;
        end else if (v == b64sc_pkg::CODE_PAD) begin
          if (phase_r == 2'd2 && pad_r == 2'd0) begin
            pad_nxt   = 2'd1;
            phase_nxt = 2'd3;
          end else if (phase_r == 2'd3) begin
            pad_nxt   = pad_r + 2'd1;
            phase_nxt = 2'd0;
          end else begin
            fault = 1'b1;
          end
        end else if (v != b64sc_pkg::CODE_SKIP) begin
          if (pad_r != 2'd0) begin
            fault = 1'b1;
          end else begin
            case (phase_r)
              2'd0: begin
                carry_nxt = v[5:0];
                phase_nxt = 2'd1;
              end
              2'd1: begin
                emit      = 1'b1;
                emit_b    = {carry_r[5:0], v[5:4]};
                carry_nxt = {2'b00, v[3:0]};
                phase_nxt = 2'd2;
              end
              2'd2: begin
                emit      = 1'b1;
                emit_b    = {carry_r[3:0], v[5:2]};
                carry_nxt = {4'b0000, v[1:0]};
                phase_nxt = 2'd3;
              end
              default: begin
                emit      = 1'b1;
                emit_b    = {carry_r[1:0], v[5:0]};
                carry_nxt = 6'd0;
                phase_nxt = 2'd0;
              end
            endcase
          end
        end
        // one-deep hold so the final byte can carry out_last
        if (emit) begin
          if (held_v_r) begin
            res.ent[k].ob = held_r;
            k = k + 1'b1;
          end
          held_nxt   = emit_b;
          held_v_nxt = 1'b1;
        end
        if (!fault && in_last && (phase_nxt != 2'd0 || !held_v_nxt)) fault = 1'b1;
        if (fault) begin
          res.ent    = '0;
          res.ent[0].err = 1'b1;
          k          = CNT_W'(1);
          err_nxt    = 1'b1;
          held_v_nxt = 1'b0;
        end else if (in_last) begin
          res.ent[k].ob = held_nxt;
          k = k + 1'b1;
        end
      end else if (in_last) begin
        res.ent[0].err = 1'b1;
        k = CNT_W'(1);
      end
      if (in_last) res.ent[k - 1'b1].last = 1'b1;
      res.n = k;
    end

    if (in_last) begin
      phase_nxt  = 2'd0;
      carry_nxt  = 6'd0;
      line_nxt   = '0;
      pad_nxt    = 2'd0;
      err_nxt    = 1'b0;
      held_nxt   = 8'h00;
      held_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      phase_r  <= 2'd0;
      carry_r  <= 6'd0;
      line_r   <= '0;
      pad_r    <= 2'd0;
      err_r    <= 1'b0;
      held_r   <= 8'h00;
      held_v_r <= 1'b0;
    end else if (load) begin
      phase_r  <= phase_nxt;
      carry_r  <= carry_nxt;
      line_r   <= line_nxt;
      pad_r    <= pad_nxt;
      err_r    <= err_nxt;
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
    end
  end

endmodule

### rtl/core/base64_stream_codec_top.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming base64 encoder/decoder with line wrapping and an APB mode register.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : one byte per transfer with is_last on the final byte of a message.
//   out_ch  : one result per transfer (out_byte, out_last, error).
//   APB     : register 0 at address 0 is mode (0 encode, 1 decode). Writing it
//             also clears the message state; write only while the block is idle.
// Flow: an item is taken into an input register, then expanded in one pass
//   into a result buffer, from which its results are presented in order.
// Throughput: an item holds the result buffer until all of its results
//   have transferred, so the result channel sets the rate. Encode yields
//   four characters per three bytes plus line breaks, up to five results
//   for a final byte with padding; a decode item yields at most two.
// Reset: synchronous, active low; mode returns to encode, buffers empty.
// Stall: while out_ch.ready is low the current result holds; one further
//   input item waits in the input register, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module base64_stream_codec_top #(
  parameter int unsigned LINE_CHARS = b64sc_pkg::LINE_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  b64sc_in_if.sink            in_ch,
  b64sc_out_if.source         out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CNT_W = b64sc_pkg::CNT_W;

  logic                 mode_r;
  logic                 cfg_wr;
  logic                 hold_v_r;
  logic [7:0]           hold_byte_r;
  logic                 hold_last_r;
  b64sc_pkg::res_t      buf_r [b64sc_pkg::MAX_RES];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 out_xfer;
  logic                 buf_free;
  logic                 load;
  b64sc_pkg::res_list_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == b64sc_pkg::REG_MODE);
  assign prdata = (paddr[2] == b64sc_pkg::REG_MODE) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64sc_pkg::MODE_ENC;
    end else if (cfg_wr) begin
      mode_r <= pwdata[0];
    end
  end

  assign out_xfer = out_ch.valid && out_ch.ready;
  // buffer frees when empty or when its last result transfers this cycle
  assign buf_free = (cnt_r == '0) || (out_xfer && (idx_r + 1'b1 == cnt_r));
  assign load     = hold_v_r && buf_free;
  assign in_ch.ready = !hold_v_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_v_r <= 1'b1;
    end else if (load) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_byte_r <= in_ch.data_byte;
      hold_last_r <= in_ch.is_last;
    end
  end

  b64sc_engine #(
    .LINE_CHARS (LINE_CHARS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (mode_r),
    .clr     (cfg_wr),
    .load    (load),
    .in_byte (hold_byte_r),
    .in_last (hold_last_r),
    .res     (res)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = res.n;
      idx_nxt = '0;
    end else if (out_xfer) begin
      if (idx_r + 1'b1 == cnt_r) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < b64sc_pkg::MAX_RES; i++) buf_r[i] <= res.ent[i];
    end
  end

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.out_byte = buf_r[idx_r].ob;
  assign out_ch.out_last = buf_r[idx_r].last;
  assign out_ch.error    = buf_r[idx_r].err;

endmodule

### sim/base64_stream_codec_top_tb.sv
// ----------------------------------------------------------------------------
// base64_stream_codec_top_tb
// Self-checking bench for the streaming base64 codec: bytes and characters are
// fed through the input stream, every result is checked in order against a
// built-in model of the encoder/decoder, and the mode register is switched
// between phases over the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module base64_stream_codec_top_tb;

  localparam int unsigned LINE_CHARS  = b64sc_pkg::LINE_CHARS_DEF;
  localparam int unsigned LINE_LEN    = ((LINE_CHARS / 4) * 4 < 4) ? 4 : (LINE_CHARS / 4) * 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 37;
  localparam int unsigned DRAIN_CYC   = 10;
  localparam logic [2:0]  MODE_ADDR   = {b64sc_pkg::REG_MODE, 2'b00};
  localparam string       SEXTETS     =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } feed_t;

  typedef logic [7:0] text_q_t [$];

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  b64sc_in_if  in_ch ();
  b64sc_out_if out_ch ();

  base64_stream_codec_top #(
    .LINE_CHARS (LINE_CHARS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // stimulus and scoreboard storage
  feed_t                byte_feed_q [$];
  b64sc_pkg::res_t      out_due_q [$];
  b64sc_pkg::res_t      step_res [$];
  int unsigned          fail_cnt;
  int unsigned          cyc_cnt;
  int unsigned          n_fed;
  logic                 in_taken;
  bit                   src_steady;
  bit                   snk_steady;
  bit                   hold_arm;
  int unsigned          hold_left;

  // codec model state
  logic       cur_mode;
  logic [1:0] grp_phase;
  logic [5:0] carry;
  int         line_cnt;
  logic [1:0] pads;
  logic       err_lat;
  logic [7:0] held_b;
  logic       held_v;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.is_last  = 1'b0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_taken       = 1'b0;
  end

  // ---------------------------------------------------------------- model --

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    return SEXTETS[int'(v)];
  endfunction

  function automatic logic [6:0] char_class(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    if (c == b64sc_pkg::CH_PAD) return b64sc_pkg::CODE_PAD;
    if (c == " " || c == "\t" || c == b64sc_pkg::CH_NL) return b64sc_pkg::CODE_SKIP;
    return b64sc_pkg::CODE_BAD;
  endfunction

  task automatic clear_msg();
    grp_phase = '0;
    carry     = '0;
    line_cnt  = 0;
    pads      = '0;
    err_lat   = 1'b0;
    held_b    = '0;
    held_v    = 1'b0;
  endtask

  task automatic put_res(input logic [7:0] b, input logic err);
    step_res.push_back('{ob: b, last: 1'b0, err: err});
  endtask

  task automatic put_char(input logic [7:0] c);
    put_res(c, 1'b0);
    line_cnt++;
    if (line_cnt >= LINE_LEN) begin
      put_res(b64sc_pkg::CH_NL, 1'b0);
      line_cnt = 0;
    end
  endtask

  task automatic hold_byte(input logic [7:0] b);
    if (held_v) put_res(held_b, 1'b0);
    held_b = b;
    held_v = 1'b1;
  endtask

  task automatic encode_step(input logic [7:0] d, input logic last);
    case (grp_phase)
      2'd0: begin
        put_char(sextet_char(d[7:2]));
        carry     = {d[1:0], 4'b0};
        grp_phase = 2'd1;
      end
      2'd1: begin
        put_char(sextet_char(carry | {2'b0, d[7:4]}));
        carry     = {d[3:0], 2'b0};
        grp_phase = 2'd2;
      end
      default: begin
        put_char(sextet_char(carry | {4'b0, d[7:6]}));
        put_char(sextet_char(d[5:0]));
        carry     = '0;
        grp_phase = 2'd0;
      end
    endcase
    if (last) begin
      if (grp_phase == 2'd1) begin
        put_char(sextet_char(carry));
        put_char(b64sc_pkg::CH_PAD);
        put_char(b64sc_pkg::CH_PAD);
      end else if (grp_phase == 2'd2) begin
        put_char(sextet_char(carry));
        put_char(b64sc_pkg::CH_PAD);
      end
      // a line that ended right at the message end already has its newline
      if (line_cnt != 0) put_res(b64sc_pkg::CH_NL, 1'b0);
    end
  endtask

  task automatic decode_step(input logic [7:0] c, input logic last);
    logic [6:0] v;
    bit         fault;
    v     = char_class(c);
    fault = 1'b0;
    if (!err_lat) begin
      if (v == b64sc_pkg::CODE_BAD) begin
        fault = 1'b1;
      end else if (v == b64sc_pkg::CODE_PAD) begin
        if (grp_phase == 2'd2 && pads == 2'd0) begin
          pads      = 2'd1;
          grp_phase = 2'd3;
        end else if (grp_phase == 2'd3) begin
          pads      = pads + 2'd1;
          grp_phase = 2'd0;
        end else begin
          fault = 1'b1;
        end
      end else if (v != b64sc_pkg::CODE_SKIP) begin
        if (pads != 2'd0) begin
          fault = 1'b1;
        end else begin
          case (grp_phase)
            2'd0: begin
              carry     = v[5:0];
              grp_phase = 2'd1;
            end
            2'd1: begin
              hold_byte({carry, v[5:4]});
              carry     = {2'b0, v[3:0]};
              grp_phase = 2'd2;
            end
            2'd2: begin
              hold_byte({carry[3:0], v[5:2]});
              carry     = {4'b0, v[1:0]};
              grp_phase = 2'd3;
            end
            default: begin
              hold_byte({carry[1:0], v[5:0]});
              carry     = '0;
              grp_phase = 2'd0;
            end
          endcase
        end
      end
      if (!fault && last && (grp_phase != 2'd0 || !held_v)) fault = 1'b1;
      if (fault) begin
        // bytes from this item are dropped along with the held one
        step_res.delete();
        put_res(8'h00, 1'b1);
        err_lat = 1'b1;
        held_v  = 1'b0;
      end else if (last) begin
        put_res(held_b, 1'b0);
      end
    end else if (last) begin
      put_res(8'h00, 1'b1);
    end
  endtask

  task automatic codec_step(input logic [7:0] d, input logic last);
    if (cur_mode == b64sc_pkg::MODE_ENC) encode_step(d, last);
    else decode_step(d, last);
    if (last) begin
      step_res[step_res.size() - 1].last = 1'b1;
      clear_msg();
    end
    foreach (step_res[i]) out_due_q.push_back(step_res[i]);
    step_res.delete();
  endtask

  // ------------------------------------------------------ driver / monitor --

  always @(negedge clk) begin : feed_drv
    feed_t nxt;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (byte_feed_q.size() != 0 && (src_steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = byte_feed_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.is_last   <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_arm) begin
      hold_left = 120;
      hold_arm  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= snk_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic note_fail(input string what);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : result_mon
    b64sc_pkg::res_t e;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) codec_step(in_ch.data_byte, in_ch.is_last);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (out_due_q.size() == 0) begin
        note_fail($sformatf("unexpected result byte=%h last=%b err=%b",
                            out_ch.out_byte, out_ch.out_last, out_ch.error));
      end else begin
        e = out_due_q.pop_front();
        if (out_ch.out_byte !== e.ob || out_ch.out_last !== e.last ||
            out_ch.error !== e.err)
          note_fail($sformatf("exp byte=%h last=%b err=%b, got byte=%h last=%b err=%b",
                              e.ob, e.last, e.err,
                              out_ch.out_byte, out_ch.out_last, out_ch.error));
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus --

  task automatic push_msg(input text_q_t txt);
    foreach (txt[i]) begin
      byte_feed_q.push_back('{data: txt[i], last: (i == txt.size() - 1)});
      n_fed++;
    end
  endtask

  task automatic push_text(input string s);
    text_q_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    push_msg(txt);
  endtask

  task automatic enc_rand(input int n);
    text_q_t txt;
    repeat (n) txt.push_back(8'($urandom_range(255)));
    push_msg(txt);
  endtask

  function automatic logic [7:0] skip_char();
    case ($urandom_range(2))
      0:       return " ";
      1:       return "\t";
      default: return b64sc_pkg::CH_NL;
    endcase
  endfunction

  // base64 text of n random bytes, optionally damaged, with whitespace sprinkled in
  task automatic dec_msg(input int n, input int flaw);
    text_q_t    raw;
    text_q_t    txt;
    text_q_t    spaced;
    logic [7:0] b0, b1, b2;
    int         pos;
    repeat (n) raw.push_back(8'($urandom_range(255)));
    for (int i = 0; i < n; i += 3) begin
      b0 = raw[i];
      b1 = (i + 1 < n) ? raw[i + 1] : 8'h00;
      b2 = (i + 2 < n) ? raw[i + 2] : 8'h00;
      txt.push_back(sextet_char(b0[7:2]));
      txt.push_back(sextet_char({b0[1:0], b1[7:4]}));
      txt.push_back((i + 1 < n) ? sextet_char({b1[3:0], b2[7:6]}) : b64sc_pkg::CH_PAD);
      txt.push_back((i + 2 < n) ? sextet_char(b2[5:0]) : b64sc_pkg::CH_PAD);
    end
    pos = $urandom_range(txt.size() - 1);
    case (flaw)
      1: txt[pos] = 8'($urandom_range(255));
      2: void'(txt.pop_back());
      3: txt.insert(pos, b64sc_pkg::CH_PAD);
      4: txt.push_back(sextet_char(6'($urandom_range(63))));
      default: ;
    endcase
    foreach (txt[i]) begin
      if ($urandom_range(7) == 0) spaced.push_back(skip_char());
      spaced.push_back(txt[i]);
    end
    if ($urandom_range(9) == 0) spaced.push_back(skip_char());
    push_msg(spaced);
  endtask

  task automatic dec_rand_msg();
    text_q_t txt;
    int      r;
    r = $urandom_range(99);
    if (r < 70) begin
      dec_msg($urandom_range(1, 9), 0);
    end else if (r < 85) begin
      dec_msg($urandom_range(1, 9), $urandom_range(1, 4));
    end else if (r < 93) begin
      repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(255)));
      push_msg(txt);
    end else begin
      repeat ($urandom_range(1, 3)) txt.push_back(skip_char());
      push_msg(txt);
    end
  endtask

  task automatic enc_rand_msg();
    if ($urandom_range(9) == 0) enc_rand($urandom_range(40, 60));
    else enc_rand($urandom_range(1, 8));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (byte_feed_q.size() != 0 || in_ch.valid || out_due_q.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {31'b0, m};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    cur_mode = m;
    clear_msg();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== {31'b0, cur_mode})
      note_fail($sformatf("mode readback exp %0d got %h", cur_mode, prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic hold_off_burst();
    src_steady = 1'b1;
    hold_arm   = 1'b1;
    repeat (6) enc_rand($urandom_range(2, 5));
    do @(negedge clk);
    while (hold_arm || hold_left != 0);
    src_steady = 1'b0;
  endtask

  initial begin : main
    int unsigned mark;
    fail_cnt   = 0;
    cyc_cnt    = 0;
    n_fed      = 0;
    src_steady = 1'b0;
    snk_steady = 1'b0;
    hold_arm   = 1'b0;
    hold_left  = 0;
    cur_mode   = b64sc_pkg::MODE_ENC;
    clear_msg();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: padding on both short tails, extreme byte values
    set_mode(b64sc_pkg::MODE_ENC);
    enc_rand(0 + 1);
    begin : enc_dir
      text_q_t t;
      t.push_back(8'h00);
      push_msg(t);
      t.delete();
      t.push_back(8'hFF);
      t.push_back(8'hFF);
      push_msg(t);
    end

    // directed decode: pads with stray low bits, skips, each kind of fault
    set_mode(b64sc_pkg::MODE_DEC);
    push_text("QR==");
    push_text("QU\tI=\n");
    push_text("Q*Q");
    push_text(" ");
    push_text("Q=");
    push_text("QQ=A");
    push_text("QQ");

    // random encode, starting with a message whose last line ends exactly
    set_mode(b64sc_pkg::MODE_ENC);
    mark = n_fed;
    enc_rand(48);
    enc_rand(51);
    hold_off_burst();
    while (n_fed < mark + 100) enc_rand_msg();
    wait_idle();
    src_steady = 1'b1;
    snk_steady = 1'b1;
    repeat (6) enc_rand_msg();
    wait_idle();
    src_steady = 1'b0;
    snk_steady = 1'b0;

    set_mode(b64sc_pkg::MODE_DEC);
    mark = n_fed;
    while (n_fed < mark + 35) dec_rand_msg();

    set_mode(b64sc_pkg::MODE_ENC);
    mark = n_fed;
    while (n_fed < mark + 10) enc_rand_msg();

    set_mode(b64sc_pkg::MODE_DEC);
    mark = n_fed;
    while (n_fed < mark + 10) dec_rand_msg();

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/b64sc_pkg.sv
rtl/core/b64sc_if.sv
rtl/core/b64sc_engine.sv
rtl/core/base64_stream_codec_top.sv
sim/base64_stream_codec_top_tb.sv
